@@ design/ensm_pkg.sv @@
package ensm_pkg;

	// Frame geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int DIM_BITS   = 11;

	// Field widths
	localparam int MAG_BITS  = 16;
	localparam int GRAD_BITS = 16;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = DIM_BITS;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [DIM_BITS-1:0]     DIM_MIN          = 11'd3;
	localparam logic [DIM_BITS-1:0]     WIDTH_MAX        = DIM_BITS'(MAX_WIDTH);
	localparam logic [DIM_BITS-1:0]     HEIGHT_MAX       = DIM_BITS'(MAX_HEIGHT);

	// Direction binning: tan 22.5 and tan 67.5 degrees in Q16
	localparam int TAN_LO_Q16 = 27146;
	localparam int TAN_HI_Q16 = 158218;
	localparam int FRAC_BITS  = 16;
	localparam int X_BITS     = GRAD_BITS;
	localparam int Y_BITS     = GRAD_BITS + 1;
	localparam int P1_BITS    = X_BITS + 15;
	localparam int P2_BITS    = X_BITS + 18;
	localparam int CMP_BITS   = P2_BITS + 2;

	typedef enum logic [1:0] {
		DIR_HORZ,
		DIR_MAIN,
		DIR_ANTI,
		DIR_VERT
	} dir_t;

	typedef struct packed {
		logic signed [GRAD_BITS-1:0] grad_x;
		logic signed [GRAD_BITS-1:0] grad_y;
		logic [MAG_BITS-1:0]         magnitude;
	} in_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] out_row;
		logic [COL_BITS-1:0] out_col;
		logic                is_peak;
		logic                last_of_frame;
	} out_t;

	// One line buffer word: two magnitude rows and the previous row's gradients
	typedef struct packed {
		logic [MAG_BITS-1:0]         top;
		logic [MAG_BITS-1:0]         mid;
		logic signed [GRAD_BITS-1:0] gx;
		logic signed [GRAD_BITS-1:0] gy;
	} mem_word_t;

	// Stage-one control handed to the judging logic
	typedef struct packed {
		logic                advance;
		logic                produce;
		logic                last;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} s1_ctl_t;

	// Pre-multiplied gradient terms for direction binning
	typedef struct packed {
		logic                       gx_zero;
		logic                       gy_zero;
		logic signed [Y_BITS-1:0]   y;
		logic [P1_BITS-1:0]         p1;
		logic [P2_BITS-1:0]         p2;
	} dir_prep_t;

endpackage

@@ design/ensm_line_mem.sv @@
module ensm_line_mem (
	input  logic                             clk,
	input  logic                             re,
	input  logic [ensm_pkg::COL_BITS-1:0]    raddr,
	output ensm_pkg::mem_word_t              rdata,
	input  logic                             we,
	input  logic [ensm_pkg::COL_BITS-1:0]    waddr,
	input  ensm_pkg::mem_word_t              wdata
);

	ensm_pkg::mem_word_t mem [ensm_pkg::MAX_WIDTH];

	// Write one column entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while no new pixel enters
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ensm_judge.sv @@
module ensm_judge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ensm_pkg::s1_ctl_t     ctl,
	input  ensm_pkg::in_t         pix,
	input  ensm_pkg::mem_word_t   rd,
	input  logic                  out_stall,
	output logic                  out_valid,
	output ensm_pkg::out_t        out_data
);

	logic [ensm_pkg::MAG_BITS-1:0]       win_q [6];
	ensm_pkg::dir_prep_t                 dir_q;
	ensm_pkg::dir_prep_t                 prep;
	logic [ensm_pkg::X_BITS-1:0]         x_abs;
	logic signed [ensm_pkg::Y_BITS-1:0]  y_ext;
	logic signed [ensm_pkg::CMP_BITS-1:0] a_v;
	logic signed [ensm_pkg::CMP_BITS-1:0] p1_v;
	logic signed [ensm_pkg::CMP_BITS-1:0] p2_v;
	ensm_pkg::dir_t                      bin;
	logic [ensm_pkg::MAG_BITS-1:0]       n1;
	logic [ensm_pkg::MAG_BITS-1:0]       n2;
	logic                                peak;
	logic                                out_valid_q;
	ensm_pkg::out_t                      out_q;

	// Fold the sign of gx into gy and scale |gx| by both tangents
	always_comb begin
		y_ext = {rd.gy[ensm_pkg::GRAD_BITS-1], rd.gy};
		if (rd.gx[ensm_pkg::GRAD_BITS-1]) begin
			x_abs  = ensm_pkg::X_BITS'(~rd.gx + 1'b1);
			prep.y = -y_ext;
		end else begin
			x_abs  = ensm_pkg::X_BITS'(rd.gx);
			prep.y = y_ext;
		end
		prep.gx_zero = (rd.gx == '0);
		prep.gy_zero = (rd.gy == '0);
		prep.p1 = ensm_pkg::P1_BITS'(x_abs) * ensm_pkg::P1_BITS'(ensm_pkg::TAN_LO_Q16);
		prep.p2 = ensm_pkg::P2_BITS'(x_abs) * ensm_pkg::P2_BITS'(ensm_pkg::TAN_HI_Q16);
	end

	// Shift the 3x3 window and the direction terms by one column
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= rd.top;
			win_q[1] <= rd.mid;
			win_q[2] <= pix.magnitude;
			dir_q    <= prep;
		end
	end

	// Bin the center pixel's gradient direction
	always_comb begin
		a_v  = {{(ensm_pkg::CMP_BITS - ensm_pkg::Y_BITS - ensm_pkg::FRAC_BITS){dir_q.y[ensm_pkg::Y_BITS-1]}},
			dir_q.y, {ensm_pkg::FRAC_BITS{1'b0}}};
		p1_v = $signed({{(ensm_pkg::CMP_BITS - ensm_pkg::P1_BITS){1'b0}}, dir_q.p1});
		p2_v = $signed({{(ensm_pkg::CMP_BITS - ensm_pkg::P2_BITS){1'b0}}, dir_q.p2});
		priority if (dir_q.gx_zero) begin
			bin = dir_q.gy_zero ? ensm_pkg::DIR_HORZ : ensm_pkg::DIR_VERT;
		end else if (a_v <= p1_v && a_v > -p1_v) begin
			bin = ensm_pkg::DIR_HORZ;
		end else if (a_v <= p2_v && a_v > p1_v) begin
			bin = ensm_pkg::DIR_MAIN;
		end else if (a_v <= -p1_v && a_v > -p2_v) begin
			bin = ensm_pkg::DIR_ANTI;
		end else begin
			bin = ensm_pkg::DIR_VERT;
		end
	end

	// Pick the two neighbors along the binned direction and compare
	always_comb begin
		unique case (bin)
			ensm_pkg::DIR_HORZ: begin
				n1 = win_q[4];
				n2 = rd.mid;
			end
			ensm_pkg::DIR_MAIN: begin
				n1 = win_q[3];
				n2 = pix.magnitude;
			end
			ensm_pkg::DIR_ANTI: begin
				n1 = win_q[5];
				n2 = rd.top;
			end
			default: begin
				n1 = win_q[0];
				n2 = win_q[2];
			end
		endcase
		peak = (win_q[1] > n1) && (win_q[1] > n2);
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.advance && ctl.produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance && ctl.produce) begin
			out_q.out_row       <= ctl.row - 1'b1;
			out_q.out_col       <= ctl.col - 1'b1;
			out_q.is_peak       <= peak;
			out_q.last_of_frame <= ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ design/edge_non_maximum_suppression.sv @@
// Output: once the pixel that completes a 3x3 window is accepted, its result is loaded
//   into the output register as that pixel leaves the line buffer read stage.
// Throughput: one pixel per cycle unless stalled, one line RAM read and write per cycle.
// Reset: frame size returns to 1024 x 1024, position to row 0 column 0, pipeline empties;
//   the line RAM is not cleared, as no result reads an entry this frame has not written.
module edge_non_maximum_suppression (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ensm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ensm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ensm_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ensm_pkg::out_t                      out_data
);

	logic [ensm_pkg::DIM_BITS-1:0] width_q;
	logic [ensm_pkg::DIM_BITS-1:0] height_q;
	logic [ensm_pkg::DIM_BITS-1:0] cfg_clamped;
	logic [ensm_pkg::ROW_BITS-1:0] row_q;
	logic [ensm_pkg::COL_BITS-1:0] col_q;
	logic                          cfg_hit;
	logic                          accept;
	logic                          col_end;
	logic                          row_end;
	logic                          valid_s1;
	ensm_pkg::in_t                 pix_s1;
	logic [ensm_pkg::ROW_BITS-1:0] row_s1;
	logic [ensm_pkg::COL_BITS-1:0] col_s1;
	ensm_pkg::s1_ctl_t             ctl;
	ensm_pkg::mem_word_t           rd;
	ensm_pkg::mem_word_t           wd;

	// Saturate a written dimension into its legal range
	always_comb begin
		cfg_hit = cfg_we && (cfg_index == ensm_pkg::CFG_FRAME_WIDTH ||
			cfg_index == ensm_pkg::CFG_FRAME_HEIGHT);
		priority if (cfg_data < ensm_pkg::DIM_MIN) begin
			cfg_clamped = ensm_pkg::DIM_MIN;
		end else if (cfg_index == ensm_pkg::CFG_FRAME_WIDTH &&
			cfg_data > ensm_pkg::WIDTH_MAX) begin
			cfg_clamped = ensm_pkg::WIDTH_MAX;
		end else if (cfg_index == ensm_pkg::CFG_FRAME_HEIGHT &&
			cfg_data > ensm_pkg::HEIGHT_MAX) begin
			cfg_clamped = ensm_pkg::HEIGHT_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ensm_pkg::WIDTH_MAX;
			height_q <= ensm_pkg::HEIGHT_MAX;
		end else if (cfg_we && cfg_index == ensm_pkg::CFG_FRAME_WIDTH) begin
			width_q <= cfg_clamped;
		end else if (cfg_we && cfg_index == ensm_pkg::CFG_FRAME_HEIGHT) begin
			height_q <= cfg_clamped;
		end
	end

	// Stage one moves on unless its result is blocked by a full output register
	always_comb begin
		ctl.produce = (row_s1 >= 2) && (col_s1 >= 2);
		ctl.advance = valid_s1 && (!ctl.produce || !out_valid || !out_stall);
		ctl.last    = ({1'b0, row_s1} + 11'd1 == height_q) &&
			({1'b0, col_s1} + 11'd1 == width_q);
		ctl.row     = row_s1;
		ctl.col     = col_s1;
		in_stall    = valid_s1 && !ctl.advance;
		accept      = in_valid && !in_stall;
		col_end     = ({1'b0, col_q} + 11'd1 == width_q);
		row_end     = ({1'b0, row_q} + 11'd1 == height_q);
	end

	// Raster position of the next pixel; a width or height write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Hold the accepted pixel while its line buffer word is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ctl.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// Write back: middle row moves up, this pixel becomes the middle row
	always_comb begin
		wd.top = rd.mid;
		wd.mid = pix_s1.magnitude;
		wd.gx  = pix_s1.grad_x;
		wd.gy  = pix_s1.grad_y;
	end

	ensm_line_mem u_line_mem (
		.clk   (clk),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd),
		.we    (ctl.advance),
		.waddr (col_s1),
		.wdata (wd)
	);

	ensm_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.pix       (pix_s1),
		.rd        (rd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ tb/sv/tb_edge_non_maximum_suppression.sv @@
`timescale 1ns / 1ps

module tb_edge_non_maximum_suppression;

	localparam int CLK_HALF_NS    = 10;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WIDE_ITEMS     = 150;
	localparam int TALL_ITEMS     = 200;
	localparam int TALL_DRAIN_AT  = 100;
	localparam int HOLD_ITEMS     = 200;
	localparam int RANDOM_ITEMS   = 650;
	localparam int TIMEOUT_NS     = 10_000_000;
	localparam int MAX_REPORTS    = 10;
	localparam int NO_HINT        = -1;
	localparam longint TAN22_Q16  = 27146;
	localparam longint TAN67_Q16  = 158218;
	localparam longint ONE_Q16    = 65536;

	// Register indexes past the end of the map; writes there are dropped
	localparam logic [ensm_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [ensm_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		int gx;
		int gy;
	} grad_pair_t;

	typedef struct packed {
		int gx;
		int gy;
		int mag;
		int peak;
	} stim_row_t;

	// DUT signals
	logic                               clk;
	logic                               arst_n    = 1'b0;
	logic                               cfg_we    = 1'b0;
	logic [ensm_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [ensm_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                               in_valid  = 1'b0;
	logic                               in_stall;
	ensm_pkg::in_t                      in_data   = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	ensm_pkg::out_t                     out_data;

	// Suppression model state
	int         frame_w = ensm_pkg::MAX_WIDTH;
	int         frame_h = ensm_pkg::MAX_HEIGHT;
	int         row_pos;
	int         col_pos;
	bit [15:0]  mag_two_up [ensm_pkg::MAX_WIDTH];
	bit [15:0]  mag_one_up [ensm_pkg::MAX_WIDTH];
	grad_pair_t grad_one_up [ensm_pkg::MAX_WIDTH];
	bit [15:0]  win_mag [6];
	grad_pair_t win_grad [2];

	ensm_pkg::out_t pending_judgements [$];

	// Run bookkeeping
	bit send_burst;
	bit recv_burst;
	bit hold_request;
	int pixels_sent;
	int judged_seen;
	int peak_count;
	int frame_ends;
	int setting_count;
	int mismatch_count;

	// One 8x3 frame: six judged pixels covering every direction bin, the
	// zero-gradient cases, both P1 boundaries, a tie and the field extremes
	stim_row_t directed_rows [24] = '{
		'{32767, -32768, 0, NO_HINT},
		'{-32768, 32767, 0, NO_HINT},
		'{0, 0, 100, NO_HINT},
		'{-1, -1, 0, NO_HINT},
		'{1, 1, 0, NO_HINT},
		'{32767, 32767, 0, NO_HINT},
		'{-32768, -32768, 0, NO_HINT},
		'{0, 0, 0, NO_HINT},
		'{-21846, 21845, 0, NO_HINT},
		'{0, 0, 65535, NO_HINT},
		'{0, 5, 100, NO_HINT},
		'{-32768, -32768, 65535, NO_HINT},
		'{32767, -32768, 0, NO_HINT},
		'{-32768, 13573, 150, NO_HINT},
		'{-32768, -13573, 200, NO_HINT},
		'{21845, -21846, 0, NO_HINT},
		'{0, 0, 0, NO_HINT},
		'{0, 0, 0, NO_HINT},
		'{7, -7, 100, 1},
		'{-7, 7, 100, 0},
		'{100, 40, 65534, 1},
		'{-100, -40, 0, 0},
		'{3, 0, 0, NO_HINT},
		'{0, -3, 0, NO_HINT}
	};

	edge_non_maximum_suppression u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Bin the slope gy/gx with Q16 cross-products; a zero gx acts as a tiny positive value
	function automatic ensm_pkg::dir_t bin_direction(input int gx, input int gy);
		longint x, y, a, p1, p2;
		if (gx == 0) begin
			return (gy == 0) ? ensm_pkg::DIR_HORZ : ensm_pkg::DIR_VERT;
		end
		x  = (gx < 0) ? -longint'(gx) : longint'(gx);
		y  = (gx < 0) ? -longint'(gy) : longint'(gy);
		a  = y * ONE_Q16;
		p1 = TAN22_Q16 * x;
		p2 = TAN67_Q16 * x;
		if (a <= p1 && a > -p1) return ensm_pkg::DIR_HORZ;
		if (a <= p2 && a > p1) return ensm_pkg::DIR_MAIN;
		if (a <= -p1 && a > -p2) return ensm_pkg::DIR_ANTI;
		return ensm_pkg::DIR_VERT;
	endfunction

	function automatic int clamp_dim(input int v, input int hi);
		if (v < ensm_pkg::DIM_MIN) return ensm_pkg::DIM_MIN;
		if (v > hi) return hi;
		return v;
	endfunction

	// Mirror a register write: a size write saturates the size and restarts the frame
	function automatic void apply_reg(input logic [ensm_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [ensm_pkg::CFG_DATA_BITS-1:0] value);
		case (idx)
			ensm_pkg::CFG_FRAME_WIDTH: begin
				frame_w = clamp_dim(int'(value), ensm_pkg::MAX_WIDTH);
				row_pos = 0;
				col_pos = 0;
			end
			ensm_pkg::CFG_FRAME_HEIGHT: begin
				frame_h = clamp_dim(int'(value), ensm_pkg::MAX_HEIGHT);
				row_pos = 0;
				col_pos = 0;
			end
			default: ;
		endcase
	endfunction

	// Advance the line buffers by one pixel and judge the pixel one row up, one column left
	function automatic bit judge_pixel(input ensm_pkg::in_t px, output ensm_pkg::out_t res);
		int         gx, gy, ci;
		bit [15:0]  m, top, mid, ctr, n1, n2;
		grad_pair_t above;
		bit         hit;
		gx    = $signed(px.grad_x);
		gy    = $signed(px.grad_y);
		m     = px.magnitude;
		ci    = col_pos % ensm_pkg::MAX_WIDTH;
		top   = mag_two_up[ci];
		mid   = mag_one_up[ci];
		above = grad_one_up[ci];
		mag_two_up[ci]  = mid;
		mag_one_up[ci]  = m;
		grad_one_up[ci] = '{gx, gy};

		res = '0;
		hit = (row_pos >= 2 && col_pos >= 2);
		if (hit) begin
			ctr = win_mag[1];
			case (bin_direction(win_grad[0].gx, win_grad[0].gy))
				ensm_pkg::DIR_HORZ: begin n1 = win_mag[4]; n2 = mid; end
				ensm_pkg::DIR_MAIN: begin n1 = win_mag[3]; n2 = m; end
				ensm_pkg::DIR_ANTI: begin n1 = win_mag[5]; n2 = top; end
				default: begin n1 = win_mag[0]; n2 = win_mag[2]; end
			endcase
			res.out_row       = ensm_pkg::ROW_BITS'(row_pos - 1);
			res.out_col       = ensm_pkg::COL_BITS'(col_pos - 1);
			res.is_peak       = (ctr > n1 && ctr > n2);
			res.last_of_frame = (row_pos + 1 == frame_h && col_pos + 1 == frame_w);
		end

		// Shift the windows one column
		win_grad[1] = win_grad[0];
		win_grad[0] = above;
		win_mag[3]  = win_mag[0];
		win_mag[4]  = win_mag[1];
		win_mag[5]  = win_mag[2];
		win_mag[0]  = top;
		win_mag[1]  = mid;
		win_mag[2]  = m;

		col_pos++;
		if (col_pos >= frame_w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= frame_h) row_pos = 0;
		end
		return hit;
	endfunction

	function automatic ensm_pkg::in_t random_pixel();
		ensm_pkg::in_t px;
		px.grad_x    = ensm_pkg::GRAD_BITS'($urandom);
		px.grad_y    = ensm_pkg::GRAD_BITS'($urandom);
		px.magnitude = ensm_pkg::MAG_BITS'($urandom);
		// Bias toward zero gradients and near-equal magnitudes
		case ($urandom_range(0, 7))
			0: px.grad_x = '0;
			1: px.grad_y = '0;
			2: px.magnitude = ensm_pkg::MAG_BITS'($urandom_range(0, 3));
			3: begin
				px.grad_x = '0;
				px.grad_y = '0;
			end
			default: ;
		endcase
		return px;
	endfunction

	function automatic void note_failure(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
	endfunction

	// Offer one pixel after a random gap unless bursting, hold it until the transfer, then predict
	task automatic push_pixel(input ensm_pkg::in_t px, input int hint);
		int             gap;
		ensm_pkg::out_t res;
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
		if (judge_pixel(px, res)) begin
			if (hint != NO_HINT) res.is_peak = hint[0];
			pending_judgements = {pending_judgements, res};
		end
	endtask

	// Drop valid, wait out every expected result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_judgements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ensm_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [ensm_pkg::CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		apply_reg(idx, value);
	endtask

	task automatic write_spare();
		write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
			ensm_pkg::CFG_DATA_BITS'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic set_frame(input int w_code, input int h_code);
		write_reg(ensm_pkg::CFG_FRAME_WIDTH, ensm_pkg::CFG_DATA_BITS'(w_code));
		write_reg(ensm_pkg::CFG_FRAME_HEIGHT, ensm_pkg::CFG_DATA_BITS'(h_code));
		if ($urandom_range(0, 3) == 0) begin
			write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B,
				ensm_pkg::CFG_DATA_BITS'($urandom));
		end
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	// Accept results after random stalls and compare them with the oldest prediction
	initial begin : result_sink
		int             pause;
		ensm_pkg::out_t got;
		ensm_pkg::out_t want;
		wait (arst_n === 1'b1);
		forever begin
			pause = recv_burst ? 0 : $urandom_range(0, 15);
			if (hold_request) begin
				pause        = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = out_data;
			judged_seen++;
			if (got.is_peak === 1'b1) peak_count++;
			if (got.last_of_frame === 1'b1) frame_ends++;
			if (pending_judgements.size() == 0) begin
				note_failure($sformatf("unexpected result row %0d col %0d peak %0b last %0b",
					got.out_row, got.out_col, got.is_peak, got.last_of_frame));
			end else begin
				want = pending_judgements.pop_front();
				if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
						got.is_peak !== want.is_peak ||
						got.last_of_frame !== want.last_of_frame) begin
					note_failure($sformatf(
						{"expected row %0d col %0d peak %0b last %0b, ",
						"got row %0d col %0d peak %0b last %0b"},
						want.out_row, want.out_col, want.is_peak, want.last_of_frame,
						got.out_row, got.out_col, got.is_peak, got.last_of_frame));
				end
			end
		end
	end

	initial begin : stimulus
		ensm_pkg::in_t px;
		int            w_code, h_code, area, burst_len, random_count;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame with hand-checked peak flags
		set_frame(8, 3);
		foreach (directed_rows[i]) begin
			px.grad_x    = ensm_pkg::GRAD_BITS'(directed_rows[i].gx);
			px.grad_y    = ensm_pkg::GRAD_BITS'(directed_rows[i].gy);
			px.magnitude = ensm_pkg::MAG_BITS'(directed_rows[i].mag);
			push_pixel(px, directed_rows[i].peak);
		end
		settle();

		// Widest frame: the all-ones width code saturates, so the first row never ends
		set_frame(2047, 3);
		send_burst = 1'b1;
		repeat (WIDE_ITEMS) push_pixel(random_pixel(), NO_HINT);
		settle();

		// Narrowest width from a zero code under a saturated height, with a mid-frame
		// drain and a dropped write
		set_frame(0, 1025);
		send_burst = 1'b0;
		for (int i = 0; i < TALL_ITEMS; i++) begin
			if (i == TALL_DRAIN_AT) begin
				settle();
				write_spare();
			end
			push_pixel(random_pixel(), NO_HINT);
		end
		settle();

		// Back-pressure: hold the output while pixels keep coming
		set_frame(10, 20);
		send_burst   = 1'b1;
		recv_burst   = 1'b0;
		hold_request = 1'b1;
		repeat (HOLD_ITEMS) push_pixel(random_pixel(), NO_HINT);
		settle();

		// Random frame sizes, partial frames and frames that wrap
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			w_code = $urandom_range(3, 16);
			h_code = $urandom_range(3, 10);
			if ($urandom_range(0, 9) == 0) w_code = $urandom_range(0, 2);
			if ($urandom_range(0, 9) == 0) h_code = $urandom_range(0, 2);
			set_frame(w_code, h_code);
			area = frame_w * frame_h;
			case ($urandom_range(0, 2))
				0: burst_len = $urandom_range(1, area);
				1: burst_len = area;
				default: burst_len = area + $urandom_range(1, area);
			endcase
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			repeat (burst_len) begin
				if ($urandom_range(0, 99) == 0) begin
					settle();
					if ($urandom_range(0, 1) != 0) write_spare();
				end
				push_pixel(random_pixel(), NO_HINT);
				random_count++;
			end
			settle();
		end

		$display("Sent %0d pixels over %0d frame sizes; checked %0d judged pixels",
			pixels_sent, setting_count, judged_seen);
		$display("(%0d peaks, %0d frame ends), saturated size codes, a long output hold.",
			peak_count, frame_ends);
		if (mismatch_count == 0 && pending_judgements.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatch_count,
				pending_judgements.size());
			$display("Verification failed");
		end
		$finish;
	end

	// Bound the run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding", pending_judgements.size());
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/ensm_pkg.sv
design/ensm_line_mem.sv
design/ensm_judge.sv
design/edge_non_maximum_suppression.sv
tb/sv/tb_edge_non_maximum_suppression.sv
